### src/rem_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and types of the Roberts edge magnitude block.
// No dependencies; every other file depends on this package.
package rem_pkg;

    localparam int PIX_W     = 8;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int OCOL_W    = 10;
    localparam int ROW_W     = 12;
    localparam int WID_W     = 11;
    localparam int MIN_DIM   = 3;

    localparam int COEF_BITS = 4;
    localparam int NTAP      = 9;
    localparam int MASK_W    = NTAP * COEF_BITS;
    localparam int CFG_W     = MASK_W;
    localparam int G_W       = PIX_W + COEF_BITS + $clog2(NTAP);
    localparam int SQ_W      = 2 * G_W;
    localparam int NSUM_W    = SQ_W + 1;

    localparam int ROOT_W    = 8;
    localparam int ROOT_IN_W = 2 * ROOT_W;
    localparam int ROOT_MAX  = (1 << ROOT_W) - 1;
    localparam int SAT_LIMIT = ROOT_MAX * ROOT_MAX + ROOT_MAX + 1;
    localparam int NSTAGE    = ROOT_W + 4;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MASK_A       = 2'd2,
        REG_MASK_B       = 2'd3
    } t_reg_idx;

    localparam logic [WID_W-1:0]  WIDTH_RST  = WID_W'(640);
    localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(480);
    localparam logic [MASK_W-1:0] MASK_A_RST = MASK_W'(65551);
    localparam logic [MASK_W-1:0] MASK_B_RST = MASK_W'(69376);

    typedef logic [NTAP-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              done;
    } t_pos;

    typedef struct packed {
        t_win win;
        t_pos pos;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_beat;

endpackage

### src/rem_if.sv
`timescale 1ns / 1ps
// Stream interfaces of the Roberts edge magnitude block: pixel in, result out.
// Depends on rem_pkg for the field widths.
interface rem_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rem_pkg::PIX_W-1:0]  pixel;
    logic                       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface rem_res_if;
    logic                        valid;
    logic                        ready;
    logic [rem_pkg::ROOT_W-1:0]  edge_value;
    logic [rem_pkg::ROW_W-1:0]   out_row;
    logic [rem_pkg::OCOL_W-1:0]  out_col;
    logic                        frame_done;

    modport source (output valid, output edge_value, output out_row, output out_col,
                    output frame_done, input ready);
    modport sink   (input valid, input edge_value, input out_row, input out_col,
                    input frame_done, output ready);
endinterface

### src/rem_front.sv
`timescale 1ns / 1ps
// Front end: raster position, two line stores, 3x3 window and the emit decision.
// Depends on rem_pkg and rem_pix_if; feeds window beats to rem_queue.
module rem_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rem_pkg::WID_W-1:0]   i_image_width,
    input  logic [rem_pkg::ROW_W-1:0]   i_image_height,
    rem_pix_if.sink                     i_pix,
    output rem_pkg::t_q_beat            o_push,
    input  logic                        i_push_ready
);
    import rem_pkg::*;

    logic [PIX_W-1:0] r_mem_up  [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_up, r_rd_mid;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_win             r_win, n_win;

    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_pix;
    logic [COL_W-1:0] r_b_col;
    logic             r_b_emit;
    t_pos             r_b_pos;
    logic             r_b_fwd;
    logic [PIX_W-1:0] r_fwd_top, r_fwd_mid;

    logic [WID_W-1:0] w_eff, w_last;
    logic [ROW_W-1:0] h_eff, h_last;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;
    logic             accept, b_adv, emit;
    t_pos             cur_pos;
    logic [PIX_W-1:0] top_res, mid_res;

    always_comb begin
        if (i_image_width < WID_W'(MIN_DIM)) begin
            w_eff = WID_W'(MIN_DIM);
        end else if (i_image_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = i_image_width;
        end
        h_eff  = (i_image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : i_image_height;
        w_last = w_eff - WID_W'(1);
        h_last = h_eff - ROW_W'(1);
    end

    always_comb begin
        r_cur = i_pix.frame_start ? '0 : r_row;
        c_cur = i_pix.frame_start ? '0 : r_col;
        if (WID_W'(c_cur) >= w_last) begin
            n_col = '0;
            n_row = (r_cur >= h_last) ? '0 : r_cur + ROW_W'(1);
        end else begin
            n_col = c_cur + COL_W'(1);
            n_row = r_cur;
        end
        emit         = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
        cur_pos.row  = r_cur - ROW_W'(1);
        cur_pos.col  = OCOL_W'(c_cur - COL_W'(1));
        cur_pos.done = (r_cur == h_last) && (WID_W'(c_cur) == w_last);
    end

    assign b_adv       = r_b_valid && (!r_b_emit || i_push_ready);
    assign i_pix.ready = !r_b_valid || b_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    assign top_res = r_b_fwd ? r_fwd_top : r_rd_up;
    assign mid_res = r_b_fwd ? r_fwd_mid : r_rd_mid;

    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[3*i]   = r_win[3*i+1];
            n_win[3*i+1] = r_win[3*i+2];
        end
        n_win[2] = top_res;
        n_win[5] = mid_res;
        n_win[8] = r_b_pix;
    end

    assign o_push.valid    = r_b_valid && r_b_emit;
    assign o_push.item.win = n_win;
    assign o_push.item.pos = r_b_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_win     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (b_adv) begin
                r_win <= n_win;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // hold the beat in stage B; catch a write to the same entry in this edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix   <= i_pix.pixel;
            r_b_col   <= c_cur;
            r_b_emit  <= emit;
            r_b_pos   <= cur_pos;
            r_b_fwd   <= r_b_valid && b_adv && (c_cur == r_b_col);
            r_fwd_top <= mid_res;
            r_fwd_mid <= r_b_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_mem_up[r_b_col]  <= mid_res;
            r_mem_mid[r_b_col] <= r_b_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_up  <= r_mem_up[c_cur];
            r_rd_mid <= r_mem_mid[c_cur];
        end
    end

endmodule

### src/rem_queue.sv
`timescale 1ns / 1ps
// Short FIFO of window beats between the front end and the arithmetic back end.
// Depends on rem_pkg.
module rem_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rem_pkg::t_q_beat  i_push,
    output logic              o_push_ready,
    output rem_pkg::t_q_beat  o_pop,
    input  logic              i_pop_ready
);
    import rem_pkg::*;

    t_q_item            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push, do_pop;

    assign o_push_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_pop.valid  = r_cnt != '0;
    assign o_pop.item   = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

### src/rem_back.sv
`timescale 1ns / 1ps
// Back end: mask sums, squares, saturation test, bit-per-stage root and rounding.
// Depends on rem_pkg and rem_res_if; pops window beats from rem_queue.
module rem_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rem_pkg::MASK_W-1:0] i_mask_a,
    input  logic [rem_pkg::MASK_W-1:0] i_mask_b,
    input  rem_pkg::t_q_beat           i_pop,
    output logic                       o_pop_ready,
    rem_res_if.source                  o_res
);
    import rem_pkg::*;

    localparam int LAST = NSTAGE - 1;

    logic                 r_vld [NSTAGE];
    t_pos                 r_pos [NSTAGE];

    logic signed [G_W-1:0] r_g1, r_g2, n_g1, n_g2;
    logic [SQ_W-1:0]       r_sq1, r_sq2;
    logic [G_W-1:0]        mag1, mag2;
    logic [NSUM_W-1:0]     nsum;
    logic [ROOT_IN_W-1:0]  r_n;
    logic                  r_sat;

    logic [ROOT_W-1:0]     r_rt  [ROOT_W];
    logic [ROOT_IN_W-1:0]  r_rn  [ROOT_W];
    logic                  r_rsat[ROOT_W];
    logic [ROOT_W-1:0]     base_r [ROOT_W];
    logic [ROOT_IN_W-1:0]  base_n [ROOT_W];
    logic                  base_s [ROOT_W];
    logic [ROOT_W-1:0]     n_rt   [ROOT_W];
    logic [ROOT_W-1:0]     trial  [ROOT_W];
    logic [ROOT_IN_W-1:0]  trial_sq [ROOT_W];

    logic [ROOT_W-1:0]      rr;
    logic [ROOT_IN_W:0]     rr_lim;
    logic [ROOT_W-1:0]      r_edge, n_edge;
    logic                   en;

    assign en          = !r_vld[LAST] || o_res.ready;
    assign o_pop_ready = en;

    always_comb begin
        n_g1 = '0;
        n_g2 = '0;
        for (int k = 0; k < NTAP; k++) begin
            n_g1 = n_g1 + G_W'($signed(i_mask_a[k*COEF_BITS +: COEF_BITS]))
                        * $signed(G_W'(i_pop.item.win[k]));
            n_g2 = n_g2 + G_W'($signed(i_mask_b[k*COEF_BITS +: COEF_BITS]))
                        * $signed(G_W'(i_pop.item.win[k]));
        end
    end

    always_comb begin
        mag1 = r_g1[G_W-1] ? G_W'(-r_g1) : G_W'(r_g1);
        mag2 = r_g2[G_W-1] ? G_W'(-r_g2) : G_W'(r_g2);
        nsum = NSUM_W'(r_sq1) + NSUM_W'(r_sq2);
    end

    always_comb begin
        base_r[0] = '0;
        base_n[0] = r_n;
        base_s[0] = r_sat;
        for (int j = 1; j < ROOT_W; j++) begin
            base_r[j] = r_rt[j-1];
            base_n[j] = r_rn[j-1];
            base_s[j] = r_rsat[j-1];
        end
        for (int j = 0; j < ROOT_W; j++) begin
            trial[j]    = base_r[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            trial_sq[j] = ROOT_IN_W'(trial[j]) * ROOT_IN_W'(trial[j]);
            n_rt[j]     = (trial_sq[j] <= base_n[j]) ? trial[j] : base_r[j];
        end
    end

    always_comb begin
        rr     = r_rt[ROOT_W-1];
        rr_lim = (ROOT_IN_W+1)'(rr) * (ROOT_IN_W+1)'(rr) + (ROOT_IN_W+1)'(rr);
        if (r_rsat[ROOT_W-1]) begin
            n_edge = ROOT_W'(ROOT_MAX);
        end else if ((ROOT_IN_W+1)'(r_rn[ROOT_W-1]) > rr_lim) begin
            n_edge = rr + ROOT_W'(1);
        end else begin
            n_edge = rr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTAGE; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_pop.valid;
            for (int s = 1; s < NSTAGE; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // advance the whole pipe together
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0] <= i_pop.item.pos;
            for (int s = 1; s < NSTAGE; s++) begin
                r_pos[s] <= r_pos[s-1];
            end
            r_g1  <= n_g1;
            r_g2  <= n_g2;
            r_sq1 <= SQ_W'(mag1) * SQ_W'(mag1);
            r_sq2 <= SQ_W'(mag2) * SQ_W'(mag2);
            r_n   <= nsum[ROOT_IN_W-1:0];
            r_sat <= nsum >= NSUM_W'(SAT_LIMIT);
            for (int j = 0; j < ROOT_W; j++) begin
                r_rt[j]   <= n_rt[j];
                r_rn[j]   <= base_n[j];
                r_rsat[j] <= base_s[j];
            end
            r_edge <= n_edge;
        end
    end

    assign o_res.valid      = r_vld[LAST];
    assign o_res.edge_value = r_edge;
    assign o_res.out_row    = r_pos[LAST].row;
    assign o_res.out_col    = r_pos[LAST].col;
    assign o_res.frame_done = r_pos[LAST].done;

endmodule

### src/roberts_edge_magnitude.sv
`timescale 1ns / 1ps
// Top level of the Roberts edge magnitude block: configuration registers and wiring.
// Depends on rem_pkg, rem_if, rem_front, rem_queue and rem_back.

// Takes one 8-bit pixel per clock in raster order and, for each interior pixel, returns
// round(sqrt(g1^2 + g2^2)) saturated at 255 with its row and column; border pixels give
// no beat. A pixel is taken every cycle as long as the four-entry window queue has room.
// A result beat passes the front-end stage around the line-store read, the queue and
// then a twelve-stage arithmetic pipe (mask sums, squares, saturation test, an
// eight-stage bit-per-stage square root, rounding); it then waits for o_res ready, and
// a stalled result holds the whole arithmetic pipe. The two line stores hold 1024
// pixels each and need no clearing pass: the first two rows never produce a result.
// Write the size and mask registers only while the block is idle.
module roberts_edge_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rem_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rem_pkg::CFG_W-1:0]     i_cfg_data,
    rem_pix_if.sink                       i_pix,
    rem_res_if.source                     o_res
);
    import rem_pkg::*;

    logic [WID_W-1:0]  r_image_width;
    logic [ROW_W-1:0]  r_image_height;
    logic [MASK_W-1:0] r_mask_a, r_mask_b;

    t_q_beat w_push, w_pop;
    logic    w_push_ready, w_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_mask_a       <= MASK_A_RST;
            r_mask_b       <= MASK_B_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                REG_MASK_A:       r_mask_a       <= i_cfg_data[MASK_W-1:0];
                REG_MASK_B:       r_mask_b       <= i_cfg_data[MASK_W-1:0];
                default:          r_mask_b       <= r_mask_b;
            endcase
        end
    end

    rem_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_pix          (i_pix),
        .o_push         (w_push),
        .i_push_ready   (w_push_ready)
    );

    rem_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop        (w_pop),
        .i_pop_ready  (w_pop_ready)
    );

    rem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask_a    (r_mask_a),
        .i_mask_b    (r_mask_b),
        .i_pop       (w_pop),
        .o_pop_ready (w_pop_ready),
        .o_res       (o_res)
    );

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result beat right after reset");

    a_queue_holds_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.valid && w_push_ready) |=> w_pop.valid)
        else $error("window beat lost in queue");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.out_row != '0 && o_res.out_col != '0))
        else $error("border pixel reported");

endmodule
